// ===== hdl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared constants, codes and controller/datapath interface types for the
// discord candidate selection unit.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int SLOTS    = 256;
    localparam int MAX_LEN  = 64;
    localparam int MAX_ROWS = 4096;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int LEN_W    = $clog2(MAX_LEN);
    localparam int ROWC_W   = $clog2(MAX_ROWS) + 1;
    localparam int ROW_W    = 12;
    localparam int CNT_W    = 9;
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 32;
    localparam int DIST_W   = 38;
    localparam int SUBLEN_W = 7;
    localparam int THR_W    = 38;
    localparam int DATA_AW  = SLOT_W + LEN_W;

    localparam logic KIND_ELEM = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_SUB_LEN   = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic              rd_issue;
        logic              elem_write;
        logic              judge_start;
        logic              idx_read;
        logic              acc_clear;
        logic              dist_issue;
        logic              decide;
        logic              place;
        logic              copy_issue;
        logic              emit;
        logic [SLOT_W:0]   j;
        logic [LEN_W:0]    k;
    } t_cmd;

    typedef struct packed {
        logic [LEN_W:0]    len;
        logic              last_elem;
        logic              rows_done;
        logic              scan_done;
        logic              cur_used;
        logic              gap_ok;
        logic              place_copy;
        logic              out_free;
    } t_status;

endpackage

// ===== hdl/dcs_ram.sv =====
// ----------------------------------------------------------------------------
// dcs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module dcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcs_ctrl
// Sequencer: accepts words, walks the candidate table on each row end,
// runs the distance loop, placement, row copy and result hand-off.
// ----------------------------------------------------------------------------
module dcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_kind,
    input  logic                i_row_end,
    output logic                o_in_stall,
    output dcs_pkg::t_cmd       o_cmd,
    input  dcs_pkg::t_status    i_status
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_RDWAIT = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_CHECK  = 10'b0000001000,
        S_DIST   = 10'b0000010000,
        S_DRAIN  = 10'b0000100000,
        S_DECIDE = 10'b0001000000,
        S_PLACE  = 10'b0010000000,
        S_COPY   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } t_state;

    t_state                      r_state, n_state;
    logic [dcs_pkg::SLOT_W:0]    r_j, n_j;
    logic [dcs_pkg::LEN_W:0]     r_k, n_k;
    logic                        r_drain, n_drain;
    logic                        in_take;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.j = r_j;
        o_cmd.k = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_kind == dcs_pkg::KIND_READ) begin
                        o_cmd.rd_issue = 1'b1;
                        n_state = S_RDWAIT;
                    end else if (!i_status.rows_done) begin
                        o_cmd.elem_write = 1'b1;
                        if (i_row_end || i_status.last_elem) begin
                            o_cmd.judge_start = 1'b1;
                            n_j     = '0;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_RDWAIT: n_state = S_EMIT;
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_PLACE;
                end else if (!i_status.cur_used) begin
                    n_j = r_j + 1'b1;
                end else begin
                    o_cmd.idx_read = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.gap_ok) begin
                    o_cmd.acc_clear = 1'b1;
                    n_k     = '0;
                    n_state = S_DIST;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_DIST: begin
                o_cmd.dist_issue = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 >= i_status.len) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // let the square and accumulate stages empty
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_j     = r_j + 1'b1;
                n_state = S_SCAN;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_k = '0;
                n_state = i_status.place_copy ? S_COPY : S_EMIT;
            end
            S_COPY: begin
                o_cmd.copy_issue = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k == (dcs_pkg::LEN_W+1)'(dcs_pkg::MAX_LEN - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= '0;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("controller state not one-hot");
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_status.scan_done |=> (r_state == S_PLACE))
        else $error("table walk did not end in placement");
    a_dist_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIST) |-> (r_k < i_status.len))
        else $error("distance loop ran past row length");

endmodule

// ===== hdl/dcs_dp.sv =====
// ----------------------------------------------------------------------------
// dcs_dp
// Datapath: configuration, row buffer, candidate table memories, squared
// distance unit, placement bookkeeping and output register.
// ----------------------------------------------------------------------------
module dcs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [dcs_pkg::THR_W-1:0]         i_cfg_data,
    input  logic signed [dcs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [dcs_pkg::SLOT_W-1:0]        i_slot,
    input  dcs_pkg::t_cmd                     i_cmd,
    output dcs_pkg::t_status                  o_status,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [dcs_pkg::ROW_W-1:0]         o_row_index,
    output logic                              o_accepted,
    output logic [dcs_pkg::CNT_W-1:0]         o_candidate_count,
    output logic                              o_table_full,
    output logic                              o_slot_occupied,
    output logic [dcs_pkg::ROW_W-1:0]         o_slot_row
);

    localparam int SW = dcs_pkg::SLOT_W;
    localparam int LW = dcs_pkg::LEN_W;
    localparam int SLOTS_V = dcs_pkg::SLOTS;

    logic [dcs_pkg::SUBLEN_W-1:0] r_sub_len;
    logic [dcs_pkg::THR_W-1:0]    r_thr;
    logic [SLOTS_V-1:0]           r_used;
    logic [SW-1:0]                r_insert;
    logic [SW:0]                  r_bound;
    logic [dcs_pkg::CNT_W-1:0]    r_live;
    logic [dcs_pkg::ROWC_W-1:0]   r_row_cnt;
    logic [LW:0]                  r_elem_cnt;
    logic                         r_full;
    logic                         r_keep;
    logic [SW-1:0]                r_dest;
    logic [SW-1:0]                r_rd_slot;
    logic                         r_is_read;

    logic                         r_d1_v, r_d1_mask, r_d2_v;
    logic [dcs_pkg::SQ_W-1:0]     r_sq;
    logic [dcs_pkg::DIST_W-1:0]   r_acc;

    logic                         r_cp_v, r_cp_mask;
    logic [LW-1:0]                r_cp_k;

    logic                         r_out_valid;
    logic [dcs_pkg::ROW_W-1:0]    r_o_row, r_o_srow;
    logic                         r_o_acc, r_o_full, r_o_occ;
    logic [dcs_pkg::CNT_W-1:0]    r_o_cnt;

    logic [LW:0]                  len;
    logic signed [dcs_pkg::SAMPLE_W-1:0] rb_q, sd_q;
    logic [dcs_pkg::ROW_W-1:0]    idx_q;
    logic [SW-1:0]                idx_raddr;
    logic                         idx_we;
    logic signed [dcs_pkg::SAMPLE_W:0] diff;
    logic signed [2*dcs_pkg::SAMPLE_W+1:0] prod;
    logic                         ins_free, can_app, load, rd_occ;

    // effective row length, clamped to 1..MAX_LEN
    always_comb begin
        if (r_sub_len == '0) begin
            len = (LW+1)'(1);
        end else if (r_sub_len > dcs_pkg::SUBLEN_W'(dcs_pkg::MAX_LEN)) begin
            len = (LW+1)'(dcs_pkg::MAX_LEN);
        end else begin
            len = (LW+1)'(r_sub_len);
        end
    end

    assign ins_free  = !r_used[r_insert];
    assign can_app   = r_bound < (SW+1)'(dcs_pkg::SLOTS);
    assign load      = i_cmd.emit && o_status.out_free;
    assign idx_raddr = i_cmd.rd_issue ? i_slot : i_cmd.j[SW-1:0];
    assign idx_we    = i_cmd.place && r_keep && (ins_free || can_app);
    assign rd_occ    = r_used[r_rd_slot];

    always_comb begin
        o_status.len        = len;
        o_status.last_elem  = (r_elem_cnt + 1'b1) >= len;
        o_status.rows_done  = r_row_cnt >= dcs_pkg::ROWC_W'(dcs_pkg::MAX_ROWS);
        o_status.scan_done  = i_cmd.j >= r_bound;
        o_status.cur_used   = r_used[i_cmd.j[SW-1:0]];
        o_status.gap_ok     = ({1'b0, idx_q} <= r_row_cnt)
                           && ((r_row_cnt - {1'b0, idx_q}) >= dcs_pkg::ROWC_W'(len));
        o_status.place_copy = r_keep && (ins_free || can_app);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    dcs_ram #(.WIDTH(dcs_pkg::SAMPLE_W), .DEPTH(dcs_pkg::MAX_LEN)) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.elem_write),
        .i_waddr (r_elem_cnt[LW-1:0]),
        .i_wdata (i_sample),
        .i_re    (i_cmd.dist_issue || i_cmd.copy_issue),
        .i_raddr (i_cmd.k[LW-1:0]),
        .o_rdata (rb_q)
    );

    dcs_ram #(.WIDTH(dcs_pkg::SAMPLE_W), .DEPTH(dcs_pkg::SLOTS * dcs_pkg::MAX_LEN)) u_slot_data (
        .i_clk   (i_clk),
        .i_we    (r_cp_v),
        .i_waddr ({r_dest, r_cp_k}),
        .i_wdata (r_cp_mask ? rb_q : '0),
        .i_re    (i_cmd.dist_issue),
        .i_raddr ({i_cmd.j[SW-1:0], i_cmd.k[LW-1:0]}),
        .o_rdata (sd_q)
    );

    dcs_ram #(.WIDTH(dcs_pkg::ROW_W), .DEPTH(dcs_pkg::SLOTS)) u_slot_index (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (ins_free ? r_insert : r_bound[SW-1:0]),
        .i_wdata (r_row_cnt[dcs_pkg::ROW_W-1:0]),
        .i_re    (i_cmd.rd_issue || i_cmd.idx_read),
        .i_raddr (idx_raddr),
        .o_rdata (idx_q)
    );

    // entries past the words of the current row count as zero
    assign diff = r_d1_mask ? ({rb_q[dcs_pkg::SAMPLE_W-1], rb_q} - {sd_q[dcs_pkg::SAMPLE_W-1], sd_q})
                            : (dcs_pkg::SAMPLE_W+1)'(0) - {sd_q[dcs_pkg::SAMPLE_W-1], sd_q};
    assign prod = diff * diff;

    always_ff @(posedge i_clk) begin
        r_d1_mask <= i_cmd.k < r_elem_cnt;
        r_sq      <= prod[dcs_pkg::SQ_W-1:0];
        r_cp_k    <= i_cmd.k[LW-1:0];
        r_cp_mask <= i_cmd.k < r_elem_cnt;
        if (i_cmd.rd_issue) begin
            r_rd_slot <= i_slot;
        end
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_d2_v) begin
            r_acc <= r_acc + dcs_pkg::DIST_W'(r_sq);
        end
        if (idx_we) begin
            r_dest <= ins_free ? r_insert : r_bound[SW-1:0];
        end
        if (load) begin
            if (r_is_read) begin
                r_o_row  <= '0;
                r_o_acc  <= 1'b0;
                r_o_occ  <= rd_occ;
                r_o_srow <= rd_occ ? idx_q : '0;
            end else begin
                r_o_row  <= r_row_cnt[dcs_pkg::ROW_W-1:0];
                r_o_acc  <= r_keep;
                r_o_occ  <= 1'b0;
                r_o_srow <= '0;
            end
            r_o_cnt  <= r_live;
            r_o_full <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_len   <= dcs_pkg::SUBLEN_W'(16);
            r_thr       <= '0;
            r_used      <= '0;
            r_insert    <= '0;
            r_bound     <= (SW+1)'(1);
            r_live      <= '0;
            r_row_cnt   <= '0;
            r_elem_cnt  <= '0;
            r_full      <= 1'b0;
            r_keep      <= 1'b0;
            r_is_read   <= 1'b0;
            r_d1_v      <= 1'b0;
            r_d2_v      <= 1'b0;
            r_cp_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d1_v <= i_cmd.dist_issue;
            r_d2_v <= r_d1_v;
            r_cp_v <= i_cmd.copy_issue;
            if (i_cfg_valid) begin
                if (i_cfg_index == dcs_pkg::REG_SUB_LEN) begin
                    r_sub_len <= i_cfg_data[dcs_pkg::SUBLEN_W-1:0];
                end else begin
                    r_thr <= i_cfg_data;
                end
            end
            if (i_cmd.rd_issue) begin
                r_is_read <= 1'b1;
            end
            if (i_cmd.elem_write) begin
                r_elem_cnt <= r_elem_cnt + 1'b1;
                r_is_read  <= 1'b0;
            end
            if (i_cmd.judge_start) begin
                r_keep <= 1'b1;
            end
            if (i_cmd.decide && (r_acc < r_thr)) begin
                // drop the close candidate and reject the row
                r_keep <= 1'b0;
                r_used[i_cmd.j[SW-1:0]] <= 1'b0;
                r_insert <= i_cmd.j[SW-1:0];
                if (r_live != '0) begin
                    r_live <= r_live - 1'b1;
                end
            end
            if (i_cmd.place && r_keep) begin
                if (ins_free) begin
                    r_used[r_insert] <= 1'b1;
                    r_live <= r_live + 1'b1;
                end else if (can_app) begin
                    r_used[r_bound[SW-1:0]] <= 1'b1;
                    r_bound <= r_bound + 1'b1;
                    r_live  <= r_live + 1'b1;
                end else begin
                    r_keep <= 1'b0;
                    r_full <= 1'b1;
                end
            end
            if (load && !r_is_read) begin
                r_row_cnt  <= r_row_cnt + 1'b1;
                r_elem_cnt <= '0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_row_index       = r_o_row;
    assign o_accepted        = r_o_acc;
    assign o_candidate_count = r_o_cnt;
    assign o_table_full      = r_o_full;
    assign o_slot_occupied   = r_o_occ;
    assign o_slot_row        = r_o_srow;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_live} <= {1'b0, r_bound})
        else $error("live count exceeds table bound");
    a_elem_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elem_cnt <= (LW+1)'(dcs_pkg::MAX_LEN))
        else $error("row element count overflow");
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !r_is_read |=> (r_elem_cnt == '0))
        else $error("row buffer not released after row result");

endmodule

// ===== hdl/discord_candidate_selection_unit.sv =====
// ----------------------------------------------------------------------------
// discord_candidate_selection_unit
// Range-discord candidate selection: collects rows, prunes close candidates
// and keeps a table of surviving rows.
// ----------------------------------------------------------------------------
// An element word without row end is written to the row buffer. A read word reads the slot index.
// A row end walks the table slots below the bound: a free slot is skipped, a too-recent slot
// is passed over after its index read, and a compared slot runs the distance loop over len words;
// the row is then copied into its slot when it is stored. One multiplier and one candidate
// memory read port serve the distance loop. One word is worked on at a time.
// Synchronous active-low reset clears all control state and the slot used bits.
// ----------------------------------------------------------------------------
module discord_candidate_selection_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [dcs_pkg::THR_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [dcs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_row_end,
    input  logic [dcs_pkg::SLOT_W-1:0]          i_slot,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dcs_pkg::ROW_W-1:0]           o_row_index,
    output logic                                o_accepted,
    output logic [dcs_pkg::CNT_W-1:0]           o_candidate_count,
    output logic                                o_table_full,
    output logic                                o_slot_occupied,
    output logic [dcs_pkg::ROW_W-1:0]           o_slot_row
);

    dcs_pkg::t_cmd    cmd;
    dcs_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    dcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_row_end  (i_row_end),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    dcs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_sample),
        .i_slot            (i_slot),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_row_index       (o_row_index),
        .o_accepted        (o_accepted),
        .o_candidate_count (o_candidate_count),
        .o_table_full      (o_table_full),
        .o_slot_occupied   (o_slot_occupied),
        .o_slot_row        (o_slot_row)
    );

endmodule
